// ----- sv/ipv4_source_blocklist_filter_macros.svh -----
// Assertion macros shared by the blocklist filter modules.
`ifndef IPV4_SOURCE_BLOCKLIST_FILTER_MACROS_SVH
`define IPV4_SOURCE_BLOCKLIST_FILTER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SBF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SBF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/ipv4_sbf_pkg.sv -----
// Package with the types and constants of the IPv4 source blocklist filter.
package ipv4_sbf_pkg;

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [15:0] ETHERTYPE_IPV6 = 16'h86DD;
    localparam logic [15:0] ETH_HDR_BYTES  = 16'd14;
    localparam logic [15:0] MIN_IPV4_FRAME = 16'd34;
    localparam logic [3:0]  MIN_IHL        = 4'd5;
    localparam logic [5:0]  ADDR_BITS      = 6'd32;

    // Byte positions inside the frame.
    localparam logic [15:0] POS_TYPE_HI   = 16'd12;
    localparam logic [15:0] POS_TYPE_LO   = 16'd13;
    localparam logic [15:0] POS_IHL       = 16'd14;
    localparam logic [15:0] POS_SRC_FIRST = 16'd26;
    localparam logic [15:0] POS_SRC_LAST  = 16'd29;

    typedef enum logic [1:0] {
        CMD_FRAME  = 2'd0,
        CMD_EXACT  = 2'd1,
        CMD_PREFIX = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        CAUSE_NONE      = 3'd0,
        CAUSE_SHORT_ETH = 3'd1,
        CAUSE_SHORT_IP  = 3'd2,
        CAUSE_BAD_IHL   = 3'd3,
        CAUSE_TRUNC_OPT = 3'd4,
        CAUSE_EXACT_HIT = 3'd5,
        CAUSE_PREFIX    = 3'd6,
        CAUSE_IPV6      = 3'd7
    } t_cause;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_WAIT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  frame_byte;
        logic        frame_end;
        logic [5:0]  entry_slot;
        logic        entry_enable;
        logic [31:0] entry_address;
        logic [5:0]  entry_prefix_bits;
    } t_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic clear_wr;
        logic scan_rd;
        logic load_final;
    } t_ctl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic cnt_last;
        logic need_scan;
        logic out_busy;
    } t_dp_status;

endpackage

// ----- sv/ipv4_sbf_if.sv -----
// Handshake interfaces for the input item channel and the verdict channel.
interface ipv4_sbf_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [7:0]  frame_byte;
    logic        frame_end;
    logic [5:0]  entry_slot;
    logic        entry_enable;
    logic [31:0] entry_address;
    logic [5:0]  entry_prefix_bits;

    modport source (
        output valid, cmd, frame_byte, frame_end, entry_slot, entry_enable,
               entry_address, entry_prefix_bits,
        input  ready
    );
    modport sink (
        input  valid, cmd, frame_byte, frame_end, entry_slot, entry_enable,
               entry_address, entry_prefix_bits,
        output ready
    );
endinterface

interface ipv4_sbf_verdict_if;
    logic        valid;
    logic        ready;
    logic        drop;
    logic [2:0]  drop_cause;
    logic [31:0] source_address;

    modport source (
        output valid, drop, drop_cause, source_address,
        input  ready
    );
    modport sink (
        input  valid, drop, drop_cause, source_address,
        output ready
    );
endinterface

// ----- sv/ipv4_sbf_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module ipv4_sbf_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- sv/ipv4_sbf_dp.sv -----
// Datapath: frame parser, verdict checks, table memories, scan compare and output register.
`include "ipv4_source_blocklist_filter_macros.svh"

module ipv4_sbf_dp #(
    parameter int EXACT_ENTRIES  = 64,
    parameter int PREFIX_ENTRIES = 64
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  ipv4_sbf_pkg::t_item       i_item,
    input  ipv4_sbf_pkg::t_ctl_cmd    i_cmd,
    output ipv4_sbf_pkg::t_dp_status  o_status,
    ipv4_sbf_verdict_if.source        o_verdict
);
    import ipv4_sbf_pkg::*;

    localparam int MAX_ENTRIES = (EXACT_ENTRIES > PREFIX_ENTRIES) ? EXACT_ENTRIES
                                                                 : PREFIX_ENTRIES;
    localparam int CNT_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int EX_AW = (EXACT_ENTRIES > 1) ? $clog2(EXACT_ENTRIES) : 1;
    localparam int PF_AW = (PREFIX_ENTRIES > 1) ? $clog2(PREFIX_ENTRIES) : 1;
    localparam int EX_W  = 33;
    localparam int PF_W  = 39;

    // Frame parse state.
    logic [15:0] r_byte_count, n_byte_count;
    logic [15:0] r_ether_type, n_ether_type;
    logic [3:0]  r_ihl, n_ihl;
    logic [31:0] r_src, n_src;

    // Scan state.
    logic [CNT_W-1:0] r_cnt;
    logic             r_cmp_en;
    logic [CNT_W-1:0] r_cmp_idx;
    logic [31:0]      r_key;
    logic             r_ex_hit;
    logic             r_pf_hit;

    // Output register.
    logic        r_out_valid;
    logic        r_out_drop;
    t_cause      r_out_cause;
    logic [31:0] r_out_src;

    logic        frame_in;
    logic        frame_last;
    t_cause      pre_cause;
    logic        pass_checks;
    logic [6:0]  opt_end;
    logic        direct_load;
    logic        cnt_last;
    t_cause      final_cause;

    logic [10:0] slot_ext;
    logic [5:0]  bits_clamped;
    logic        ex_wr_cmd;
    logic        pf_wr_cmd;
    logic        ex_we;
    logic        pf_we;
    logic [EX_AW-1:0] ex_waddr;
    logic [PF_AW-1:0] pf_waddr;
    logic [EX_W-1:0]  ex_wdata;
    logic [PF_W-1:0]  pf_wdata;
    logic [EX_W-1:0]  ex_rdata;
    logic [PF_W-1:0]  pf_rdata;
    logic [31:0]      pf_mask;
    logic             ex_match;
    logic             pf_match;

    // Next values of the parse registers as if the current byte were taken.
    always_comb begin
        n_ether_type = r_ether_type;
        n_ihl        = r_ihl;
        n_src        = r_src;
        if (r_byte_count == POS_TYPE_HI) begin
            n_ether_type = {i_item.frame_byte, r_ether_type[7:0]};
        end else if (r_byte_count == POS_TYPE_LO) begin
            n_ether_type = {r_ether_type[15:8], i_item.frame_byte};
        end else if (r_byte_count == POS_IHL) begin
            n_ihl = i_item.frame_byte[3:0];
        end else if (r_byte_count inside {[POS_SRC_FIRST:POS_SRC_LAST]}) begin
            n_src = {r_src[23:0], i_item.frame_byte};
        end
        n_byte_count = (r_byte_count == 16'hFFFF) ? r_byte_count : r_byte_count + 16'd1;
    end

    // Header checks that decide without looking at the tables.
    assign opt_end = 7'd14 + {1'b0, n_ihl, 2'b00};

    always_comb begin
        pre_cause   = CAUSE_NONE;
        pass_checks = 1'b0;
        if (n_byte_count < ETH_HDR_BYTES) begin
            pre_cause = CAUSE_SHORT_ETH;
        end else if (n_ether_type == ETHERTYPE_IPV6) begin
            pre_cause = CAUSE_IPV6;
        end else if (n_ether_type != ETHERTYPE_IPV4) begin
            pre_cause = CAUSE_NONE;
        end else if (n_byte_count < MIN_IPV4_FRAME) begin
            pre_cause = CAUSE_SHORT_IP;
        end else if (n_ihl < MIN_IHL) begin
            pre_cause = CAUSE_BAD_IHL;
        end else if ({9'd0, opt_end} > n_byte_count) begin
            pre_cause = CAUSE_TRUNC_OPT;
        end else begin
            pass_checks = 1'b1;
        end
    end

    assign frame_in    = (t_cmd'(i_item.cmd) == CMD_FRAME);
    assign frame_last  = frame_in && i_item.frame_end;
    assign direct_load = i_cmd.accept && frame_last && !pass_checks;
    assign cnt_last    = (r_cnt == CNT_W'(MAX_ENTRIES - 1));

    assign o_status.cnt_last  = cnt_last;
    assign o_status.need_scan = frame_last && pass_checks;
    assign o_status.out_busy  = r_out_valid && !o_verdict.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count <= '0;
            r_ether_type <= '0;
            r_ihl        <= '0;
            r_src        <= '0;
        end else if (i_cmd.accept && frame_in) begin
            if (i_item.frame_end) begin
                r_byte_count <= '0;
                r_ether_type <= '0;
                r_ihl        <= '0;
                r_src        <= '0;
            end else begin
                r_byte_count <= n_byte_count;
                r_ether_type <= n_ether_type;
                r_ihl        <= n_ihl;
                r_src        <= n_src;
            end
        end
    end

    // Table writes, and the zeroing sweep after reset.
    assign slot_ext     = {5'd0, i_item.entry_slot};
    assign bits_clamped = (i_item.entry_prefix_bits > ADDR_BITS) ? ADDR_BITS
                                                                 : i_item.entry_prefix_bits;
    assign ex_wr_cmd = i_cmd.accept && (t_cmd'(i_item.cmd) == CMD_EXACT)
                       && (slot_ext < 11'(EXACT_ENTRIES));
    assign pf_wr_cmd = i_cmd.accept && (t_cmd'(i_item.cmd) == CMD_PREFIX)
                       && (slot_ext < 11'(PREFIX_ENTRIES));

    always_comb begin
        if (i_cmd.clear_wr) begin
            ex_we    = ({1'b0, r_cnt} < (CNT_W + 1)'(EXACT_ENTRIES));
            pf_we    = ({1'b0, r_cnt} < (CNT_W + 1)'(PREFIX_ENTRIES));
            ex_waddr = r_cnt[EX_AW-1:0];
            pf_waddr = r_cnt[PF_AW-1:0];
            ex_wdata = '0;
            pf_wdata = '0;
        end else begin
            ex_we    = ex_wr_cmd;
            pf_we    = pf_wr_cmd;
            ex_waddr = slot_ext[EX_AW-1:0];
            pf_waddr = slot_ext[PF_AW-1:0];
            ex_wdata = i_item.entry_enable ? {1'b1, i_item.entry_address} : '0;
            pf_wdata = i_item.entry_enable ? {1'b1, bits_clamped, i_item.entry_address}
                                           : '0;
        end
    end

    ipv4_sbf_ram #(
        .WIDTH (EX_W),
        .DEPTH (EXACT_ENTRIES)
    ) u_exact_ram (
        .i_clk   (i_clk),
        .i_we    (ex_we),
        .i_waddr (ex_waddr),
        .i_wdata (ex_wdata),
        .i_raddr (r_cnt[EX_AW-1:0]),
        .o_rdata (ex_rdata)
    );

    ipv4_sbf_ram #(
        .WIDTH (PF_W),
        .DEPTH (PREFIX_ENTRIES)
    ) u_prefix_ram (
        .i_clk   (i_clk),
        .i_we    (pf_we),
        .i_waddr (pf_waddr),
        .i_wdata (pf_wdata),
        .i_raddr (r_cnt[PF_AW-1:0]),
        .o_rdata (pf_rdata)
    );

    // One entry of each table is compared per cycle, in the cycle after its read.
    assign pf_mask  = (pf_rdata[37:32] == 6'd0) ? 32'd0
                                                : (32'hFFFF_FFFF << (ADDR_BITS - pf_rdata[37:32]));
    assign ex_match = ({1'b0, r_cmp_idx} < (CNT_W + 1)'(EXACT_ENTRIES))
                      && ex_rdata[32] && (ex_rdata[31:0] == r_key);
    assign pf_match = ({1'b0, r_cmp_idx} < (CNT_W + 1)'(PREFIX_ENTRIES))
                      && pf_rdata[38] && (((pf_rdata[31:0] ^ r_key) & pf_mask) == 32'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_cmp_en <= 1'b0;
            r_ex_hit <= 1'b0;
            r_pf_hit <= 1'b0;
        end else begin
            if (i_cmd.clear_wr || i_cmd.scan_rd) begin
                r_cnt <= cnt_last ? '0 : r_cnt + CNT_W'(1);
            end
            r_cmp_en <= i_cmd.scan_rd;
            if (i_cmd.accept && frame_last) begin
                r_ex_hit <= 1'b0;
                r_pf_hit <= 1'b0;
            end else if (r_cmp_en) begin
                r_ex_hit <= r_ex_hit | ex_match;
                r_pf_hit <= r_pf_hit | pf_match;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_idx <= r_cnt;
        if (i_cmd.accept && frame_last) begin
            r_key <= n_src;
        end
    end

    assign final_cause = r_ex_hit ? CAUSE_EXACT_HIT : (r_pf_hit ? CAUSE_PREFIX : CAUSE_NONE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (direct_load || i_cmd.load_final) begin
            r_out_valid <= 1'b1;
        end else if (o_verdict.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (direct_load) begin
            r_out_drop  <= (pre_cause != CAUSE_NONE);
            r_out_cause <= pre_cause;
            r_out_src   <= (pre_cause == CAUSE_SHORT_ETH || pre_cause == CAUSE_IPV6
                            || n_ether_type != ETHERTYPE_IPV4
                            || pre_cause == CAUSE_SHORT_IP) ? 32'd0 : n_src;
        end else if (i_cmd.load_final) begin
            r_out_drop  <= (final_cause != CAUSE_NONE);
            r_out_cause <= final_cause;
            r_out_src   <= r_key;
        end
    end

    assign o_verdict.valid          = r_out_valid;
    assign o_verdict.drop           = r_out_drop;
    assign o_verdict.drop_cause     = r_out_cause;
    assign o_verdict.source_address = r_out_src;

    `SBF_ASSERT_NOW(a_final_free, i_clk, i_rst_n, i_cmd.load_final, !r_out_valid,
        "table verdict loaded over a pending verdict")
    `SBF_ASSERT_NOW(a_direct_free, i_clk, i_rst_n, direct_load,
        !(r_out_valid && !o_verdict.ready), "header verdict loaded over a stalled verdict")
    `SBF_ASSERT_NOW(a_no_accept_in_scan, i_clk, i_rst_n, r_cmp_en,
        !i_cmd.accept, "item accepted while a table scan is running")
endmodule

// ----- sv/ipv4_sbf_ctrl.sv -----
// Controller state machine: reset sweep, item acceptance, table scan and verdict load.
`include "ipv4_source_blocklist_filter_macros.svh"

module ipv4_sbf_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_item_valid,
    input  ipv4_sbf_pkg::t_dp_status  i_status,
    output ipv4_sbf_pkg::t_ctl_cmd    o_cmd,
    output logic                      o_item_ready
);
    import ipv4_sbf_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_status.cnt_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (o_cmd.accept && i_status.need_scan) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_status.cnt_last) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT:  n_state = S_DONE;
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd        = '0;
        o_item_ready = 1'b0;
        case (r_state)
            S_CLEAR: o_cmd.clear_wr = 1'b1;
            S_IDLE: begin
                o_item_ready = !i_status.out_busy;
                o_cmd.accept = i_item_valid && !i_status.out_busy;
            end
            S_SCAN:  o_cmd.scan_rd = 1'b1;
            S_WAIT:  o_cmd = '0;
            S_DONE:  o_cmd.load_final = 1'b1;
            default: o_cmd = '0;
        endcase
    end

    `SBF_ASSERT_NEXT(a_scan_start, i_clk, i_rst_n,
        (r_state == S_IDLE) && o_cmd.accept && i_status.need_scan, r_state == S_SCAN,
        "frame passing the header checks did not start a table scan")
    `SBF_ASSERT_NEXT(a_scan_end, i_clk, i_rst_n,
        (r_state == S_SCAN) && i_status.cnt_last, (r_state == S_WAIT) && !o_item_ready,
        "table scan did not finish after its last entry")
endmodule

// ----- sv/ipv4_source_blocklist_filter.sv -----
// Top level of the IPv4 source blocklist filter.
//
// Items arrive on i_item: a frame byte (with a last-byte mark) or a write of one
// entry of the exact-address table or of the prefix table. At each last byte the
// block gives one verdict on o_verdict: drop flag, cause and captured source.
// Table writes and non-final frame bytes give no verdict.
// A frame whose header already decides the verdict (short, IPv6, other type, bad
// header length) has its verdict in the output register in the cycle after the last
// byte is taken. An IPv4 frame that passes the header checks is compared against both
// tables, one entry of each per cycle from the one read port of each memory; its
// verdict is loaded into the output register after the scan and a wait state, and
// no item is accepted meanwhile.
// After reset both tables are zeroed by a sweep over their entries; i_item.ready
// stays low during the sweep.
// A verdict waits in the output register while the receiver stalls; items are
// still taken then unless the register is full and not being drained.
module ipv4_source_blocklist_filter #(
    parameter int EXACT_ENTRIES  = 64,
    parameter int PREFIX_ENTRIES = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    ipv4_sbf_item_if.sink      i_item,
    ipv4_sbf_verdict_if.source o_verdict
);
    import ipv4_sbf_pkg::*;

    t_item      item;
    t_ctl_cmd   ctl_cmd;
    t_dp_status dp_status;
    logic       item_ready;

    assign item.cmd               = i_item.cmd;
    assign item.frame_byte        = i_item.frame_byte;
    assign item.frame_end         = i_item.frame_end;
    assign item.entry_slot        = i_item.entry_slot;
    assign item.entry_enable      = i_item.entry_enable;
    assign item.entry_address     = i_item.entry_address;
    assign item.entry_prefix_bits = i_item.entry_prefix_bits;
    assign i_item.ready           = item_ready;

    ipv4_sbf_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (i_item.valid),
        .i_status     (dp_status),
        .o_cmd        (ctl_cmd),
        .o_item_ready (item_ready)
    );

    ipv4_sbf_dp #(
        .EXACT_ENTRIES  (EXACT_ENTRIES),
        .PREFIX_ENTRIES (PREFIX_ENTRIES)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (item),
        .i_cmd     (ctl_cmd),
        .o_status  (dp_status),
        .o_verdict (o_verdict)
    );
endmodule

// ----- dv/tb_ipv4_source_blocklist_filter.sv -----
// Self-checking testbench of the IPv4 source blocklist filter: directed and random frames and table writes.
module tb_ipv4_source_blocklist_filter;
    timeunit 1ns;
    timeprecision 1ps;

    import ipv4_sbf_pkg::*;

    localparam int EXACT_N     = 64;
    localparam int PREFIX_N    = 64;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int DRAIN_WAIT  = 200;
    localparam int REPORT_MAX  = 10;
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic [15:0] ETHERTYPE_LLDP = 16'h88CC;

    typedef struct {
        logic        drop;
        t_cause      cause;
        logic [31:0] src;
    } t_verdict_exp;

    logic i_clk;
    logic i_rst_n;

    ipv4_sbf_item_if    item_ch ();
    ipv4_sbf_verdict_if verdict_ch ();

    ipv4_source_blocklist_filter #(
        .EXACT_ENTRIES  (EXACT_N),
        .PREFIX_ENTRIES (PREFIX_N)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (item_ch),
        .o_verdict (verdict_ch)
    );

    // Items waiting for the driver and verdicts waiting for the DUT.
    t_item        stim_items[$];
    t_verdict_exp verdicts_due[$];
    t_item        next_item;

    // Predicted filter state.
    logic [15:0] fr_count;
    logic [15:0] fr_type;
    logic [3:0]  fr_ihl;
    logic [31:0] fr_src;
    logic        blk_exact_valid [EXACT_N];
    logic [31:0] blk_exact_addr  [EXACT_N];
    logic        blk_pfx_valid   [PREFIX_N];
    logic [5:0]  blk_pfx_bits    [PREFIX_N];
    logic [31:0] blk_pfx_addr    [PREFIX_N];

    // What the generator last wrote, used only to aim sources at table entries.
    logic [31:0] aim_exact_addr [EXACT_N];
    logic [31:0] aim_pfx_addr   [PREFIX_N];
    logic [5:0]  aim_pfx_bits   [PREFIX_N];

    logic steady;
    int   items_queued;
    int   verdicts_planned;
    int   verdicts_checked;
    int   mismatches;
    int   frames_seen;
    int   writes_seen;
    int   cause_seen [8];
    int   cycle_count;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic logic [31:0] leading_mask(logic [5:0] bits);
        if (bits == 6'd0) begin
            return 32'd0;
        end
        return 32'hFFFF_FFFF << (32 - int'(bits));
    endfunction

    // Advance the predicted state by one accepted item.
    task automatic filter_step(t_item it);
        t_verdict_exp v;
        logic [5:0]   bits;
        logic         hit;
        if (it.cmd == CMD_EXACT) begin
            blk_exact_valid[it.entry_slot] = it.entry_enable;
            blk_exact_addr[it.entry_slot]  = it.entry_enable ? it.entry_address : 32'd0;
            writes_seen++;
        end else if (it.cmd == CMD_PREFIX) begin
            bits = (it.entry_prefix_bits > ADDR_BITS) ? ADDR_BITS : it.entry_prefix_bits;
            blk_pfx_valid[it.entry_slot] = it.entry_enable;
            blk_pfx_bits[it.entry_slot]  = it.entry_enable ? bits : 6'd0;
            blk_pfx_addr[it.entry_slot]  = it.entry_enable ? it.entry_address : 32'd0;
            writes_seen++;
        end else if (it.cmd == CMD_FRAME) begin
            if (fr_count == POS_TYPE_HI) begin
                fr_type[15:8] = it.frame_byte;
            end else if (fr_count == POS_TYPE_LO) begin
                fr_type[7:0] = it.frame_byte;
            end else if (fr_count == POS_IHL) begin
                fr_ihl = it.frame_byte[3:0];
            end else if (fr_count >= POS_SRC_FIRST && fr_count <= POS_SRC_LAST) begin
                fr_src = {fr_src[23:0], it.frame_byte};
            end
            if (fr_count != 16'hFFFF) begin
                fr_count = fr_count + 16'd1;
            end
            if (it.frame_end) begin
                v.src = 32'd0;
                if (fr_count < ETH_HDR_BYTES) begin
                    v.cause = CAUSE_SHORT_ETH;
                end else if (fr_type == ETHERTYPE_IPV6) begin
                    v.cause = CAUSE_IPV6;
                end else if (fr_type != ETHERTYPE_IPV4) begin
                    v.cause = CAUSE_NONE;
                end else if (fr_count < MIN_IPV4_FRAME) begin
                    v.cause = CAUSE_SHORT_IP;
                end else begin
                    v.src = fr_src;
                    if (fr_ihl < MIN_IHL) begin
                        v.cause = CAUSE_BAD_IHL;
                    end else if (int'(ETH_HDR_BYTES) + 4 * int'(fr_ihl) > int'(fr_count)) begin
                        v.cause = CAUSE_TRUNC_OPT;
                    end else begin
                        hit = 1'b0;
                        for (int i = 0; i < EXACT_N; i++) begin
                            if (blk_exact_valid[i] && blk_exact_addr[i] == fr_src) begin
                                hit = 1'b1;
                            end
                        end
                        if (hit) begin
                            v.cause = CAUSE_EXACT_HIT;
                        end else begin
                            for (int i = 0; i < PREFIX_N; i++) begin
                                if (blk_pfx_valid[i] &&
                                    ((fr_src ^ blk_pfx_addr[i]) & leading_mask(blk_pfx_bits[i]))
                                        == 32'd0) begin
                                    hit = 1'b1;
                                end
                            end
                            v.cause = hit ? CAUSE_PREFIX : CAUSE_NONE;
                        end
                    end
                end
                v.drop = (v.cause != CAUSE_NONE);
                verdicts_due.push_back(v);
                cause_seen[v.cause]++;
                frames_seen++;
                fr_count = 16'd0;
                fr_type  = 16'd0;
                fr_ihl   = 4'd0;
                fr_src   = 32'd0;
            end
        end
    endtask

    task automatic check_verdict();
        t_verdict_exp want;
        if (verdicts_due.size() == 0) begin
            if (mismatches < REPORT_MAX) begin
                $display("unexpected verdict: drop=%0b cause=%0d src=%h", verdict_ch.drop,
                         verdict_ch.drop_cause, verdict_ch.source_address);
            end
            mismatches++;
        end else begin
            want = verdicts_due.pop_front();
            if (verdict_ch.drop !== want.drop || verdict_ch.drop_cause !== want.cause ||
                verdict_ch.source_address !== want.src) begin
                if (mismatches < REPORT_MAX) begin
                    $display("verdict %0d: expected drop=%0b cause=%0d src=%h,",
                             verdicts_checked, want.drop, want.cause, want.src);
                    $display("    got drop=%0b cause=%0d src=%h", verdict_ch.drop,
                             verdict_ch.drop_cause, verdict_ch.source_address);
                end
                mismatches++;
            end
        end
        verdicts_checked++;
    endtask

    // Driver: holds an item until it is taken, then idles or offers the next one.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            item_ch.valid <= 1'b0;
        end else begin
            if (item_ch.valid && item_ch.ready) begin
                filter_step({item_ch.cmd, item_ch.frame_byte, item_ch.frame_end,
                             item_ch.entry_slot, item_ch.entry_enable,
                             item_ch.entry_address, item_ch.entry_prefix_bits});
            end
            if (!item_ch.valid || item_ch.ready) begin
                if (stim_items.size() > 0 && (steady || $urandom_range(99) >= 33)) begin
                    next_item = stim_items.pop_front();
                    item_ch.cmd               <= next_item.cmd;
                    item_ch.frame_byte        <= next_item.frame_byte;
                    item_ch.frame_end         <= next_item.frame_end;
                    item_ch.entry_slot        <= next_item.entry_slot;
                    item_ch.entry_enable      <= next_item.entry_enable;
                    item_ch.entry_address     <= next_item.entry_address;
                    item_ch.entry_prefix_bits <= next_item.entry_prefix_bits;
                    item_ch.valid             <= 1'b1;
                end else begin
                    item_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks every verdict taken and stalls the output at random unless steady is set.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            verdict_ch.ready <= 1'b0;
        end else begin
            if (verdict_ch.valid && verdict_ch.ready) begin
                check_verdict();
            end
            verdict_ch.ready <= steady || ($urandom_range(99) >= 33);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d verdicts outstanding", cycle_count,
                     verdicts_due.size());
            $display("FAILURE");
            $finish;
        end
    end

    task automatic send_write(t_cmd cmd, logic [5:0] slot, logic en, logic [31:0] addr,
                              logic [5:0] bits);
        t_item it;
        it.cmd               = cmd;
        it.frame_byte        = 8'($urandom);
        it.frame_end         = 1'($urandom);
        it.entry_slot        = slot;
        it.entry_enable      = en;
        it.entry_address     = addr;
        it.entry_prefix_bits = bits;
        stim_items.push_back(it);
        items_queued++;
        if (cmd == CMD_EXACT) begin
            aim_exact_addr[slot] = addr;
        end else begin
            aim_pfx_addr[slot] = addr;
            aim_pfx_bits[slot] = (bits > ADDR_BITS) ? ADDR_BITS : bits;
        end
    endtask

    task automatic send_noise();
        t_item it;
        it = t_item'({$urandom, $urandom, $urandom});
        it.cmd = CMD_UNUSED;
        stim_items.push_back(it);
    endtask

    // Queue one frame: random filler with the type, version/IHL byte and source in place.
    task automatic send_frame(int len, logic [15:0] etype, logic [7:0] ver_ihl,
                              logic [31:0] src);
        t_item it;
        for (int i = 0; i < len; i++) begin
            it = t_item'({$urandom, $urandom, $urandom});
            it.cmd = CMD_FRAME;
            it.frame_end = (i == len - 1);
            case (i)
                12: it.frame_byte = etype[15:8];
                13: it.frame_byte = etype[7:0];
                14: it.frame_byte = ver_ihl;
                26: it.frame_byte = src[31:24];
                27: it.frame_byte = src[23:16];
                28: it.frame_byte = src[15:8];
                29: it.frame_byte = src[7:0];
                default: ;
            endcase
            stim_items.push_back(it);
        end
        items_queued += len;
        verdicts_planned++;
    endtask

    function automatic logic [31:0] pick_source();
        int          r;
        logic [5:0]  s;
        logic [31:0] m;
        r = $urandom_range(99);
        s = 6'($urandom);
        if (r < 40) begin
            return aim_exact_addr[s];
        end else if (r < 70) begin
            m = leading_mask(aim_pfx_bits[s]);
            return (aim_pfx_addr[s] & m) | ($urandom & ~m);
        end
        return $urandom;
    endfunction

    task automatic random_phase(int n_items, int n_verdicts);
        int          start_items;
        int          start_verdicts;
        int          r;
        int          ihl;
        int          len;
        logic [15:0] etype;
        logic [3:0]  ver;
        logic [5:0]  bits;
        start_items    = items_queued;
        start_verdicts = verdicts_planned;
        while (items_queued - start_items < n_items ||
               verdicts_planned - start_verdicts < n_verdicts) begin
            r = $urandom_range(99);
            if (r < 10) begin
                send_write(CMD_EXACT, 6'($urandom), $urandom_range(99) < 80, $urandom,
                           6'($urandom));
            end else if (r < 20) begin
                case ($urandom_range(19))
                    0: bits = 6'($urandom_range(1, 7));
                    1, 2, 3: bits = 6'($urandom_range(33, 63));
                    default: bits = 6'($urandom_range(8, 32));
                endcase
                send_write(CMD_PREFIX, 6'($urandom), $urandom_range(99) < 80, $urandom, bits);
            end else if (r < 22) begin
                send_noise();
            end else if (r < 80) begin
                ihl = ($urandom_range(3) == 0) ? $urandom_range(5, 15) : 5;
                len = 14 + 4 * ihl + $urandom_range(0, 30);
                ver = ($urandom_range(9) == 0) ? 4'($urandom) : 4'd4;
                send_frame(len, ETHERTYPE_IPV4, {ver, 4'(ihl)}, pick_source());
            end else begin
                etype = 16'($urandom);
                if (etype == ETHERTYPE_IPV4 || etype == ETHERTYPE_IPV6) begin
                    etype = etype ^ 16'h0001;
                end
                case ($urandom_range(5))
                    0: send_frame($urandom_range(1, 13), etype, 8'($urandom), $urandom);
                    1: send_frame($urandom_range(14, 60), ETHERTYPE_IPV6, 8'($urandom),
                                  $urandom);
                    2: send_frame($urandom_range(14, 60), etype, 8'($urandom), $urandom);
                    3: send_frame($urandom_range(14, 33), ETHERTYPE_IPV4, 8'h45, $urandom);
                    4: send_frame($urandom_range(34, 60), ETHERTYPE_IPV4,
                                  {4'($urandom), 4'($urandom_range(0, 4))}, pick_source());
                    default: begin
                        ihl = $urandom_range(6, 15);
                        send_frame($urandom_range(34, 13 + 4 * ihl), ETHERTYPE_IPV4,
                                   {4'd4, 4'(ihl)}, pick_source());
                    end
                endcase
            end
        end
    endtask

    // Returns once every queued item is taken and every verdict has come back.
    task automatic wait_drained();
        @(negedge i_clk);
        while (stim_items.size() != 0 || item_ch.valid || verdicts_due.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    initial begin
        i_rst_n                   = 1'b0;
        item_ch.valid             = 1'b0;
        item_ch.cmd               = CMD_FRAME;
        item_ch.frame_byte        = 8'd0;
        item_ch.frame_end         = 1'b0;
        item_ch.entry_slot        = 6'd0;
        item_ch.entry_enable      = 1'b0;
        item_ch.entry_address     = 32'd0;
        item_ch.entry_prefix_bits = 6'd0;
        verdict_ch.ready          = 1'b0;
        steady                    = 1'b0;
        fr_count = 16'd0;
        fr_type  = 16'd0;
        fr_ihl   = 4'd0;
        fr_src   = 32'd0;
        for (int i = 0; i < EXACT_N; i++) begin
            blk_exact_valid[i] = 1'b0;
            blk_exact_addr[i]  = 32'd0;
            aim_exact_addr[i]  = 32'd0;
        end
        for (int i = 0; i < PREFIX_N; i++) begin
            blk_pfx_valid[i] = 1'b0;
            blk_pfx_bits[i]  = 6'd0;
            blk_pfx_addr[i]  = 32'd0;
            aim_pfx_addr[i]  = 32'd0;
            aim_pfx_bits[i]  = 6'd0;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Header checks in the order the block applies them.
        send_frame(1, ETHERTYPE_IPV4, 8'h45, 32'd0);
        send_frame(13, ETHERTYPE_IPV4, 8'h45, 32'd0);
        send_frame(14, ETHERTYPE_IPV6, 8'h60, 32'd0);
        send_frame(20, ETHERTYPE_LLDP, 8'hFF, 32'hFFFF_FFFF);
        send_frame(33, ETHERTYPE_IPV4, 8'h45, 32'h0102_0304);
        send_frame(34, ETHERTYPE_IPV4, 8'h44, 32'h0102_0304);
        send_frame(34, ETHERTYPE_IPV4, 8'h40, 32'h0000_0000);
        send_frame(37, ETHERTYPE_IPV4, 8'h46, 32'h0102_0304);
        send_frame(38, ETHERTYPE_IPV4, 8'h46, 32'h0102_0304);
        send_frame(73, ETHERTYPE_IPV4, 8'h4F, 32'h0102_0305);
        send_frame(74, ETHERTYPE_IPV4, 8'h4F, 32'h0102_0305);
        // Table lookups; the /45 entry is kept as a /32.
        send_write(CMD_EXACT, 6'd0, 1'b1, 32'hC0A8_0001, 6'd0);
        send_write(CMD_EXACT, 6'd63, 1'b1, 32'hFFFF_FFFF, 6'd63);
        send_write(CMD_PREFIX, 6'd5, 1'b1, 32'h0A00_0000, 6'd8);
        send_write(CMD_PREFIX, 6'd62, 1'b1, 32'hAC10_0005, 6'd45);
        send_write(CMD_EXACT, 6'd1, 1'b1, 32'h0A00_00FF, 6'd0);
        send_noise();
        send_frame(34, ETHERTYPE_IPV4, 8'h45, 32'hC0A8_0001);
        send_frame(60, ETHERTYPE_IPV4, 8'h45, 32'hFFFF_FFFF);
        send_frame(40, ETHERTYPE_IPV4, 8'h45, 32'h0A12_3456);
        send_frame(40, ETHERTYPE_IPV4, 8'h45, 32'hAC10_0005);
        send_frame(40, ETHERTYPE_IPV4, 8'h45, 32'hAC10_0004);
        send_frame(40, ETHERTYPE_IPV4, 8'h45, 32'h0A00_00FF);
        send_frame(34, ETHERTYPE_IPV4, 8'h95, 32'h0102_0304);
        // A zero-length prefix matches everything until it is removed.
        send_write(CMD_PREFIX, 6'd7, 1'b1, 32'h5A5A_A5A5, 6'd0);
        send_frame(34, ETHERTYPE_IPV4, 8'h45, 32'h0102_0304);
        send_write(CMD_PREFIX, 6'd7, 1'b0, 32'h5A5A_A5A5, 6'd20);
        send_write(CMD_EXACT, 6'd0, 1'b0, 32'hC0A8_0001, 6'd0);
        send_frame(34, ETHERTYPE_IPV4, 8'h45, 32'hC0A8_0001);
        wait_drained();

        random_phase(120, 3);
        wait_drained();

        steady = 1'b1;
        random_phase(120, 3);
        wait_drained();
        steady = 1'b0;

        random_phase(40, 1);
        wait_drained();
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Covered %0d frames and %0d table writes;", frames_seen, writes_seen);
        $display("%0d verdicts checked, %0d mismatches.", verdicts_checked, mismatches);
        $display("Causes none/eth/ip/ihl/opt/exact/prefix/v6: %0d %0d %0d %0d %0d %0d %0d %0d",
                 cause_seen[0], cause_seen[1], cause_seen[2], cause_seen[3],
                 cause_seen[4], cause_seen[5], cause_seen[6], cause_seen[7]);
        if (mismatches == 0 && verdicts_due.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
